@@ design/edfml_pkg.sv @@
// Shared types, widths and helpers for the EDF maximum-lateness tracker.
// Used by the slot memory, the sequencer and the top level; depends on nothing.
package edfml_pkg;

  localparam int DL_W      = 10;
  localparam int DUR_W     = 16;
  localparam int WORK_W    = 32;
  localparam int LATE_W    = 33;
  localparam int OUT_W     = 31;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 32;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  // Position width: covers both the deadline field and the slot index, plus one bit so that
  // stepping past the last slot stays visible.
  localparam int POS_W  = ((SLOT_W > DL_W) ? SLOT_W : DL_W) + 1;

  localparam logic [WORK_W-1:0] SAT = {WORK_W{1'b1}};

  // One memory word per deadline slot: the used mark, the work booked at that slot alone,
  // and the Fenwick node.
  typedef struct packed {
    logic              used;
    logic [WORK_W-1:0] point;
    logic [WORK_W-1:0] node;
  } slot_word_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_word_t        wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [WORK_W-1:0] sat_add(input logic [WORK_W-1:0] a,
                                                input logic [WORK_W-1:0] b);
    logic [WORK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORK_W] ? SAT : s[WORK_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] low_bit(input logic [POS_W-1:0] x);
    return x & (~x + POS_W'(1));
  endfunction

endpackage

@@ design/edf_max_lateness_tracker.sv @@
// EDF maximum-lateness tracker: takes one task per beat (deadline, duration) and returns one
// beat with the worst lateness over all admitted tasks, clamped to 0..2^31-1. After reset the block
// runs a clearing pass over all 1024 slots of its slot memory before it takes the first beat.
// A task then books its work at up to 10 Fenwick nodes, runs the prefix query over up to 10
// nodes, and, when its deadline lies at or after the current worst point, rescans every slot
// after the deadline up to slot 1023. Every update, query and rescan step goes through the
// single read port of the slot memory. A task with deadline zero leaves the state alone.
// A new task is taken while the previous result still waits.
// Depends on edfml_pkg, edfml_seq and edfml_slot_ram.
module edf_max_lateness_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [edfml_pkg::S_TDATA_W-1:0]     s_tdata,  // deadline[9:0], duration[25:10]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [edfml_pkg::M_TDATA_W-1:0]     m_tdata   // max_lateness[30:0]
);
  import edfml_pkg::*;

  mem_req_t                 mem_req;
  slot_word_t               mem_rdata;
  logic                     ready;
  logic                     done;
  logic                     out_free;
  logic signed [LATE_W-1:0] worst;
  logic [OUT_W-1:0]         clamped;

  assign s_tready = ready;
  assign out_free = !m_tvalid || m_tready;

  edfml_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_tvalid && ready),
    .deadline  (s_tdata[DL_W-1:0]),
    .duration  (s_tdata[DL_W+DUR_W-1:DL_W]),
    .out_free  (out_free),
    .ready     (ready),
    .done      (done),
    .worst     (worst),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  edfml_slot_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (worst[LATE_W-1] || worst == '0) begin
      clamped = '0;
    end else if (worst[LATE_W-2:OUT_W] != '0) begin
      clamped = {OUT_W{1'b1}};
    end else begin
      clamped = worst[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= M_TDATA_W'(clamped);
    end
  end

endmodule

@@ design/edfml_slot_ram.sv @@
// Single-port-write, single-read slot memory holding the Fenwick nodes, the per-slot work
// and the used marks. Depends on edfml_pkg.
module edfml_slot_ram (
  input  logic                  clk,
  input  edfml_pkg::mem_req_t   req,
  output edfml_pkg::slot_word_t rdata
);
  import edfml_pkg::*;

  slot_word_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ design/edfml_seq.sv @@
// Sequencer of the lateness tracker: clearing pass, Fenwick update and prefix query,
// and the rescan of later deadlines. Depends on edfml_pkg and drives edfml_slot_ram.
module edfml_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [edfml_pkg::DL_W-1:0]    deadline,
  input  logic [edfml_pkg::DUR_W-1:0]   duration,
  input  logic                          out_free,
  output logic                          ready,
  output logic                          done,
  output logic signed [edfml_pkg::LATE_W-1:0] worst,
  output edfml_pkg::mem_req_t           mem_req,
  input  edfml_pkg::slot_word_t         mem_rdata
);
  import edfml_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ADD_RD = 4'd2;
  localparam logic [3:0] ST_ADD_WR = 4'd3;
  localparam logic [3:0] ST_Q_RD   = 4'd4;
  localparam logic [3:0] ST_Q_ACC  = 4'd5;
  localparam logic [3:0] ST_DECIDE = 4'd6;
  localparam logic [3:0] ST_SCAN   = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  logic [3:0]               state, state_next;
  logic [SLOT_W-1:0]        clr, clr_next;
  logic [POS_W-1:0]         pos, pos_next;
  logic [POS_W-1:0]         dl, dl_next;
  logic [DUR_W-1:0]         dur, dur_next;
  logic [WORK_W-1:0]        acc, acc_next;
  logic signed [LATE_W-1:0] worst_next;
  logic [DL_W-1:0]          wd, wd_next;
  logic [POS_W-1:0]         issue, issue_next;
  logic                     pend, pend_next;
  logic [POS_W-1:0]         pend_idx, pend_idx_next;

  logic [POS_W-1:0]         d_in;
  logic [POS_W-1:0]         step_pos;
  logic [WORK_W-1:0]        scan_acc;
  logic signed [LATE_W-1:0] here;
  logic signed [LATE_W-1:0] scan_late;
  logic signed [LATE_W:0]   shifted_sum;
  logic signed [LATE_W-1:0] shifted;
  slot_word_t               upd;

  assign d_in  = POS_W'(deadline);
  assign ready = (state == ST_IDLE);
  assign done  = (state == ST_EMIT) && out_free;

  always_comb begin
    here        = $signed(LATE_W'({1'b0, acc}) - LATE_W'(dl));
    scan_acc    = sat_add(acc, mem_rdata.point);
    scan_late   = $signed(LATE_W'({1'b0, scan_acc}) - LATE_W'(pend_idx));
    shifted_sum = $signed({worst[LATE_W-1], worst}) + $signed((LATE_W + 1)'(dur));
    if (shifted_sum > $signed((LATE_W + 1)'(SAT))) begin
      shifted = $signed(LATE_W'(SAT));
    end else begin
      shifted = shifted_sum[LATE_W-1:0];
    end
    upd      = mem_rdata;
    upd.node = sat_add(mem_rdata.node, WORK_W'(dur));
    if (pos == dl) begin
      upd.used  = 1'b1;
      upd.point = sat_add(mem_rdata.point, WORK_W'(dur));
    end
  end

  always_comb begin
    state_next    = state;
    clr_next      = clr;
    pos_next      = pos;
    dl_next       = dl;
    dur_next      = dur;
    acc_next      = acc;
    worst_next    = worst;
    wd_next       = wd;
    issue_next    = issue;
    pend_next     = 1'b0;
    pend_idx_next = pend_idx;
    step_pos      = '0;
    mem_req       = '0;
    mem_req.raddr = pos[SLOT_W-1:0];

    case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr;
        clr_next      = clr + SLOT_W'(1);
        if (clr == SLOT_W'(SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          pos_next = d_in;
          dl_next  = d_in;
          dur_next = duration;
          if (d_in == '0 || d_in >= POS_W'(SLOTS)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_ADD_RD;
          end
        end
      end
      ST_ADD_RD: begin
        state_next = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos[SLOT_W-1:0];
        mem_req.wdata = upd;
        step_pos      = pos + low_bit(pos);
        if (step_pos < POS_W'(SLOTS)) begin
          pos_next   = step_pos;
          state_next = ST_ADD_RD;
        end else begin
          pos_next = dl;
          acc_next = '0;
          if (wd == '0) begin
            // First task: its own lateness is the worst so far.
            worst_next = $signed(LATE_W'(dur) - LATE_W'(dl));
            wd_next    = dl[DL_W-1:0];
            state_next = ST_EMIT;
          end else begin
            state_next = ST_Q_RD;
          end
        end
      end
      ST_Q_RD: begin
        state_next = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        acc_next = sat_add(acc, mem_rdata.node);
        step_pos = pos - low_bit(pos);
        if (step_pos != '0) begin
          pos_next   = step_pos;
          state_next = ST_Q_RD;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (POS_W'(wd) > dl) begin
          // The worst point lies later, so it just moves by the new duration.
          if (here > shifted) begin
            worst_next = here;
            wd_next    = dl[DL_W-1:0];
          end else begin
            worst_next = shifted;
          end
          state_next = ST_EMIT;
        end else begin
          if (here >= worst) begin
            worst_next = here;
            wd_next    = dl[DL_W-1:0];
          end
          issue_next = dl + POS_W'(1);
          if (dl + POS_W'(1) < POS_W'(SLOTS)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        // Reads are issued one slot per cycle; each slot's read data joins the running prefix sum in the cycle after.
        mem_req.raddr = issue[SLOT_W-1:0];
        if (issue < POS_W'(SLOTS)) begin
          issue_next    = issue + POS_W'(1);
          pend_next     = 1'b1;
          pend_idx_next = issue;
        end else begin
          state_next = ST_EMIT;
        end
        if (pend) begin
          acc_next = scan_acc;
          if (mem_rdata.used && scan_late >= worst) begin
            worst_next = scan_late;
            wd_next    = pend_idx[DL_W-1:0];
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      worst <= '0;
      wd    <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      worst <= worst_next;
      wd    <= wd_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    dl       <= dl_next;
    dur      <= dur_next;
    acc      <= acc_next;
    issue    <= issue_next;
    pend_idx <= pend_idx_next;
  end

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == ST_CLEAR || state == ST_ADD_WR))
    else $error("slot memory written outside clearing or update");

  a_scan_above_deadline: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && pend) |-> (pend_idx > dl))
    else $error("rescan visits a slot at or below the new deadline");

  a_worst_bounded: assert property (@(posedge clk) disable iff (rst)
    worst <= $signed(LATE_W'(SAT)))
    else $error("worst lateness above saturation bound");

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule

@@ sim/tb_edf_max_lateness_tracker.sv @@
// Testbench for edf_max_lateness_tracker: drives task beats with random gaps and back-pressure,
// predicts the worst lateness with its own Fenwick-tree model and checks every result beat.
// Depends on edfml_pkg and the edf_max_lateness_tracker RTL.
`timescale 1ns / 100ps

module tb_edf_max_lateness_tracker;
  import edfml_pkg::*;

  localparam int     CYCLE_LIMIT = 8_000_000;
  localparam int     RANDOM_BEATS = 270;
  localparam int     SETTLE_CYCLES = 1100;
  localparam int     SRC = 0;
  localparam int     SNK = 1;
  localparam longint SAT_L = 64'h0000_0000_FFFF_FFFF;
  localparam longint OUT_MAX_L = 64'h0000_0000_7FFF_FFFF;

  typedef struct {
    logic [DL_W-1:0]  deadline;
    logic [DUR_W-1:0] duration;
    int               gap;
  } job_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // deadline[9:0], duration[25:10]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // max_lateness[30:0]

  edf_max_lateness_tracker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Model state: Fenwick nodes, used marks and the current worst point.
  logic [WORK_W-1:0] fen_node [SLOTS];
  bit                slot_used [SLOTS];
  longint            worst_late;
  int unsigned       worst_slot;

  job_t             pending_jobs[$];
  logic [OUT_W-1:0] expected_lateness[$];
  job_t             cur_job;
  bit               src_loaded;
  bit               s_beat_seen;
  bit               m_beat_seen;
  int               sink_hold;
  bit               sink_fresh;
  int               idle_left [2];
  bit               idle_calm [2];
  int               jobs_queued;
  int               jobs_taken;
  int               results_seen;
  int               fail_count;
  int               cycle_count;
  logic [OUT_W-1:0] want;

  function automatic void fen_add(input int unsigned pos, input logic [WORK_W-1:0] amount);
    longint s;
    while (pos != 0 && pos < SLOTS) begin
      s = longint'(fen_node[pos]) + longint'(amount);
      fen_node[pos] = (s > SAT_L) ? SAT : s[WORK_W-1:0];
      pos += pos & (~pos + 1);
    end
  endfunction

  function automatic longint fen_prefix(input int unsigned pos);
    longint s;
    s = 0;
    while (pos != 0) begin
      if (pos < SLOTS) begin
        s += longint'(fen_node[pos]);
        if (s > SAT_L) s = SAT_L;
      end
      pos -= pos & (~pos + 1);
    end
    return s;
  endfunction

  // Books one task into the model and returns the lateness beat it should produce.
  function automatic logic [OUT_W-1:0] book_job(input logic [DL_W-1:0] dl,
                                                input logic [DUR_W-1:0] dur);
    int unsigned d;
    longint      d_l;
    longint      m;
    longint      here_late;
    longint      shifted;
    longint      v;
    d   = 32'(dl);
    d_l = longint'(d);
    m   = longint'(dur);
    if (d != 0 && d < SLOTS) begin
      slot_used[d] = 1'b1;
      fen_add(d, WORK_W'(dur));
      if (worst_slot == 0) begin
        worst_late = m - d_l;
        worst_slot = d;
      end else if (worst_slot > d) begin
        // Everything at or after the old worst point moved up by the new duration.
        here_late = fen_prefix(d) - d_l;
        shifted   = worst_late + m;
        if (shifted > SAT_L) shifted = SAT_L;
        if (here_late > shifted) begin
          worst_late = here_late;
          worst_slot = d;
        end else begin
          worst_late = shifted;
        end
      end else begin
        for (int unsigned i = d; i < SLOTS; i++) begin
          if (slot_used[i]) begin
            v = fen_prefix(i) - longint'(i);
            if (v >= worst_late) begin
              worst_late = v;
              worst_slot = i;
            end
          end
        end
      end
    end
    if (worst_late <= 0) return '0;
    if (worst_late > OUT_MAX_L) return OUT_MAX_L[OUT_W-1:0];
    return worst_late[OUT_W-1:0];
  endfunction

  // Idle cycles for one beat; runs of calm beats keep stretches without any idling.
  function automatic int draw_wait(input int side);
    if (idle_left[side] == 0) begin
      idle_left[side] = $urandom_range(1, 40);
      idle_calm[side] = ($urandom_range(0, 3) == 0);
    end
    idle_left[side]--;
    return idle_calm[side] ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic queue_job(input logic [DL_W-1:0] d, input logic [DUR_W-1:0] m);
    job_t j;
    j.deadline = d;
    j.duration = m;
    j.gap      = draw_wait(SRC);
    pending_jobs.push_back(j);
    jobs_queued++;
  endtask

  task automatic queue_random(input int n);
    logic [DL_W-1:0]  d;
    logic [DUR_W-1:0] m;
    int               k;
    repeat (n) begin
      k = $urandom_range(0, 99);
      if (k < 5) d = '0;
      else if (k < 12) d = DL_W'($urandom_range(1, 16));
      else if (k < 22) d = DL_W'($urandom_range(1000, 1023));
      else d = DL_W'($urandom_range(1, 1023));
      k = $urandom_range(0, 99);
      if (k < 10) m = '0;
      else if (k < 18) m = '1;
      else if (k < 50) m = DUR_W'($urandom_range(0, 255));
      else m = DUR_W'($urandom);
      queue_job(d, m);
    end
  endtask

  task automatic wait_drained();
    while (jobs_taken != jobs_queued || expected_lateness.size() != 0) @(negedge clk);
  endtask

  // Task driver: a beat stays up until it is taken, then the next one follows its gap.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      src_loaded = 1'b0;
    end else if (!s_tvalid || s_beat_seen) begin
      if (!src_loaded && pending_jobs.size() != 0) begin
        cur_job    = pending_jobs.pop_front();
        src_loaded = 1'b1;
      end
      if (src_loaded && cur_job.gap == 0) begin
        s_tvalid   <= 1'b1;
        s_tdata    <= S_TDATA_W'({cur_job.duration, cur_job.deadline});
        src_loaded = 1'b0;
      end else begin
        s_tvalid <= 1'b0;
        if (src_loaded) cur_job.gap--;
      end
    end
  end

  // Result sink: holds ready low for a fresh random stall after every taken beat.
  always @(negedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      sink_hold  = 0;
      sink_fresh = 1'b1;
    end else begin
      if (sink_fresh || m_beat_seen) begin
        sink_hold  = draw_wait(SNK);
        sink_fresh = 1'b0;
      end
      if (sink_hold != 0) begin
        m_tready  <= 1'b0;
        sink_hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_beat_seen <= 1'b0;
      m_beat_seen <= 1'b0;
    end else begin
      s_beat_seen <= s_tvalid && s_tready;
      m_beat_seen <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) begin
        jobs_taken++;
        expected_lateness.push_back(book_job(s_tdata[DL_W-1:0], s_tdata[DL_W+DUR_W-1:DL_W]));
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_lateness.size() == 0) begin
          $error("max_lateness: no result expected, got %0d", m_tdata[OUT_W-1:0]);
          fail_count++;
        end else begin
          want = expected_lateness.pop_front();
          if (m_tdata[OUT_W-1:0] !== want) begin
            $error("max_lateness: expected %0d, got %0d", want, m_tdata[OUT_W-1:0]);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_lateness.size());
      $display("[edf_max_lateness_tracker] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      fen_node[i]  = '0;
      slot_used[i] = 1'b0;
    end
    worst_late = 0;
    worst_slot = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ignored deadline zero, first task, a prefix query that takes over from a
    // negative worst point, rescan and prefix-query ties, and the field extremes.
    queue_job(10'd0, 16'hFFFF);
    queue_job(10'd1000, 16'd0);
    queue_job(10'd5, 16'd3);
    queue_job(10'd7, 16'd4);
    queue_job(10'd9, 16'd2);
    queue_job(10'd7, 16'd10);
    queue_job(10'd1023, 16'hFFFF);
    queue_job(10'd1, 16'd0);
    queue_job(10'd0, 16'd0);
    queue_job(10'd1023, 16'd1);
    queue_job(10'd682, 16'h5555);
    queue_job(10'd341, 16'hAAAA);
    queue_job(10'd512, 16'h8000);
    queue_job(10'd1, 16'hFFFF);
    wait_drained();
    @(posedge clk);

    queue_random(RANDOM_BEATS);
    wait_drained();
    @(posedge clk);
    queue_random(RANDOM_BEATS);
    wait_drained();
    @(posedge clk);

    // A last short burst once the worst point sits at the final slot.
    queue_job(10'd1023, 16'hFFFF);
    queue_random(20);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d task beats in directed and random bursts, checked %0d lateness beats.",
             jobs_taken, results_seen);
    $display("Mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("[edf_max_lateness_tracker] OK");
    end else begin
      $display("[edf_max_lateness_tracker] ERROR");
    end
    $finish;
  end

endmodule
